### sv/ffha_pkg.sv
package ffha_pkg;

  localparam int ARENA_GRANULES = 4096;
  localparam int AW = $clog2(ARENA_GRANULES);
  localparam int VW = AW + 1;
  localparam int SW = VW + 1;
  localparam int WW = 29;
  localparam int MIN_GRAN = 3;
  localparam int GRAN_BYTES = 16;
  localparam int TAG_OVERHEAD = 24;

  localparam logic [VW-1:0] NIL = VW'(ARENA_GRANULES);
  localparam logic [SW-1:0] NIL_S = SW'(ARENA_GRANULES);

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE = 2'd1;
  localparam logic [1:0] ACT_RESIZE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NULL,
    ST_OOM,
    ST_BADPTR
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_GRAB,
    S_GRAB_SZ,
    S_WALK,
    S_WALK_EV,
    S_SPLIT_CHK,
    S_SPLIT2,
    S_SPLIT3,
    S_AFTER,
    S_CK0,
    S_CK1,
    S_CK2,
    S_RSZ0,
    S_RSZ1,
    S_REL0,
    S_REL1,
    S_REL2,
    S_REL3,
    S_REL4,
    S_REL5,
    S_REL6,
    S_REL7,
    S_DONE
  } state_t;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_CLEAR,
    CMD_LATCH,
    CMD_INIT,
    CMD_WALK_START,
    CMD_READ_B,
    CMD_WALK_NEXT,
    CMD_TAKE,
    CMD_SPLIT1,
    CMD_SPLIT2,
    CMD_PUSHB_C,
    CMD_NOSPLIT,
    CMD_RELOC,
    CMD_READ_G,
    CMD_READ_FOOT,
    CMD_INPLACE,
    CMD_READ_NX,
    CMD_GROW,
    CMD_FREE_MARK,
    CMD_MERGE_NX,
    CMD_READ_PREVF,
    CMD_READ_PB,
    CMD_MERGE_PV,
    CMD_REL_TAG,
    CMD_PUSHB_G,
    CMD_OUT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    st_we;
    status_t st;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic off_zero;
    logic n_zero;
    logic n_big;
    logic started;
    logic pre_ok;
    logic ck1_ok;
    logic ck2_ok;
    logic walk_end;
    logic walk_fit;
    logic split_ok;
    logic grow;
    logic inplace;
    logic nx_in;
    logic grow_fit;
    logic rd_free;
    logic g_nz;
    logic prev_ok;
    logic out_busy;
    logic clr_last;
  } stat_t;

endpackage

### sv/ffha_dp.sv
module ffha_dp (
  input  logic              clk,
  input  logic              rst,
  input  ffha_pkg::cmd_t    cmd,
  output ffha_pkg::stat_t   stat,
  input  logic [1:0]        in_action,
  input  logic [31:0]       in_bytes,
  input  logic [15:0]       in_offset,
  output logic              out_valid,
  input  logic              out_ready,
  output ffha_pkg::status_t out_status,
  output logic [15:0]       out_offset,
  output logic              out_moved,
  output logic [15:0]       out_copy
);
  import ffha_pkg::*;

  // Boundary tags, one entry per granule.
  logic [VW-1:0] bs_mem [ARENA_GRANULES];
  logic          iu_mem [ARENA_GRANULES];
  logic [VW-1:0] fs_mem [ARENA_GRANULES];
  logic [VW-1:0] nx_mem [ARENA_GRANULES];
  logic [VW-1:0] pv_mem [ARENA_GRANULES];

  logic [1:0]    act;
  logic [31:0]   n;
  logic [15:0]   off;
  logic [WW-1:0] want;
  logic [VW-1:0] g, sz, b, bsz, pb, visits, head;
  logic          started, grow;
  logic [AW-1:0] clr;
  logic [VW-1:0] rd_bs, rd_fs, rd_nx, rd_pv;
  logic          rd_iu;
  status_t       st;
  logic [15:0]   res, cp;
  logic          mv;

  logic [32:0]   want_sum;
  logic [WW-1:0] want_calc;
  logic [16:0]   gcalc;
  logic [SW-1:0] g_plus_rd, sz_plus_rd, g_plus_sz;
  logic [VW+3:0] cap;
  logic [VW-1:0] c_blk;

  logic          tag_en, iuo_en, iuo_v, unl_en, pa_en, pb_en, rd_en, clearing;
  logic [VW-1:0] tag_g, tag_s, iuo_a, pa_g, pb_g;
  logic          tag_u;
  logic [SW-1:0] tag_last;
  logic [AW-1:0] ra;

  logic          bs_we, iu_we, fs_we, nx_we, pv_we;
  logic [AW-1:0] bs_wa, iu_wa, fs_wa, nx_wa, pv_wa;
  logic [VW-1:0] bs_wd, fs_wd, nx_wd, pv_wd;
  logic          iu_wd;

  assign want_sum = 33'(in_bytes) + 33'(TAG_OVERHEAD + GRAN_BYTES - 1);
  assign want_calc = (want_sum[32:4] < WW'(MIN_GRAN)) ? WW'(MIN_GRAN) : want_sum[32:4];
  assign gcalc = 17'(off[15:4]) - 17'd1;
  assign g_plus_rd = SW'(g) + SW'(rd_bs);
  assign sz_plus_rd = SW'(sz) + SW'(rd_bs);
  assign g_plus_sz = SW'(g) + SW'(sz);
  assign cap = {sz, 4'b0000} - (VW+4)'(TAG_OVERHEAD);
  assign c_blk = b + want[VW-1:0];

  always_comb begin
    stat.act = act;
    stat.off_zero = (off == 16'd0);
    stat.n_zero = (n == 32'd0);
    stat.n_big = (n > 32'(ARENA_GRANULES * GRAN_BYTES));
    stat.started = started;
    stat.pre_ok = started && (off >= 16'(GRAN_BYTES)) && (off[3:0] == 4'd0) &&
                  (gcalc + 17'(MIN_GRAN) <= 17'(ARENA_GRANULES));
    stat.ck1_ok = rd_iu && (rd_bs >= VW'(MIN_GRAN)) && (g_plus_rd <= NIL_S);
    stat.ck2_ok = (rd_fs == sz);
    stat.walk_end = (b >= NIL) || (visits >= NIL);
    stat.walk_fit = (WW'(rd_bs) >= want);
    stat.split_ok = (WW'(bsz) >= want) && (WW'(bsz) - want >= WW'(MIN_GRAN));
    stat.grow = grow;
    stat.inplace = (want <= WW'(sz));
    stat.nx_in = (g_plus_sz < NIL_S);
    stat.grow_fit = !rd_iu && (WW'(sz_plus_rd) >= want);
    stat.rd_free = !rd_iu;
    stat.g_nz = (g != '0);
    stat.prev_ok = (rd_fs <= g);
    stat.out_busy = out_valid && !out_ready;
    stat.clr_last = (clr == AW'(ARENA_GRANULES - 1));
  end

  // Command decode into tag, link and read operations.
  always_comb begin
    tag_en = 1'b0; tag_g = '0; tag_s = '0; tag_u = 1'b0;
    iuo_en = 1'b0; iuo_a = '0; iuo_v = 1'b0;
    unl_en = 1'b0;
    pa_en = 1'b0; pa_g = '0;
    pb_en = 1'b0; pb_g = '0;
    rd_en = 1'b0; ra = '0;
    clearing = 1'b0;
    case (cmd.op)
      CMD_CLEAR: clearing = 1'b1;
      CMD_INIT: begin
        tag_en = 1'b1; tag_g = '0; tag_s = NIL;
        pa_en = 1'b1; pa_g = '0;
      end
      CMD_READ_B: begin rd_en = 1'b1; ra = b[AW-1:0]; end
      CMD_TAKE: unl_en = 1'b1;
      CMD_SPLIT1: begin
        tag_en = 1'b1; tag_g = b; tag_s = want[VW-1:0]; tag_u = 1'b1;
      end
      CMD_SPLIT2: begin
        tag_en = 1'b1; tag_g = c_blk; tag_s = bsz - want[VW-1:0];
        pa_en = 1'b1; pa_g = c_blk;
      end
      CMD_PUSHB_C: begin pb_en = 1'b1; pb_g = c_blk; end
      CMD_NOSPLIT: begin
        if (grow) begin
          tag_en = 1'b1; tag_g = b; tag_s = bsz; tag_u = 1'b1;
        end else begin
          iuo_en = 1'b1; iuo_a = b; iuo_v = 1'b1;
        end
      end
      CMD_READ_G: begin rd_en = 1'b1; ra = gcalc[AW-1:0]; end
      CMD_READ_FOOT: begin rd_en = 1'b1; ra = AW'(g_plus_rd - SW'(1)); end
      CMD_READ_NX: begin rd_en = 1'b1; ra = g_plus_sz[AW-1:0]; end
      CMD_GROW: unl_en = 1'b1;
      CMD_FREE_MARK: begin iuo_en = 1'b1; iuo_a = g; iuo_v = 1'b0; end
      CMD_MERGE_NX: begin
        unl_en = 1'b1;
        tag_en = 1'b1; tag_g = g; tag_s = sz_plus_rd[VW-1:0];
      end
      CMD_READ_PREVF: begin rd_en = 1'b1; ra = AW'(g - VW'(1)); end
      CMD_READ_PB: begin rd_en = 1'b1; ra = AW'(g - rd_fs); end
      CMD_MERGE_PV: begin
        unl_en = 1'b1;
        tag_en = 1'b1; tag_g = pb; tag_s = sz_plus_rd[VW-1:0];
      end
      CMD_REL_TAG: begin
        tag_en = 1'b1; tag_g = g; tag_s = sz;
        pa_en = 1'b1; pa_g = g;
      end
      CMD_PUSHB_G: begin pb_en = 1'b1; pb_g = g; end
      default: ;
    endcase
  end

  assign tag_last = SW'(tag_g) + SW'(tag_s) - SW'(1);

  always_comb begin
    bs_we = clearing || (tag_en && tag_g < NIL);
    bs_wa = clearing ? clr : tag_g[AW-1:0];
    bs_wd = clearing ? '0 : tag_s;

    iu_we = clearing || (tag_en && tag_g < NIL) || (iuo_en && iuo_a < NIL);
    iu_wa = clearing ? clr : (tag_en ? tag_g[AW-1:0] : iuo_a[AW-1:0]);
    iu_wd = clearing ? 1'b0 : (tag_en ? tag_u : iuo_v);

    fs_we = clearing || (tag_en && tag_g < NIL && tag_s != '0 && tag_last < NIL_S);
    fs_wa = clearing ? clr : tag_last[AW-1:0];
    fs_wd = clearing ? '0 : tag_s;

    nx_we = clearing || (unl_en && rd_pv < NIL) || (pa_en && pa_g < NIL);
    nx_wa = clearing ? clr : (unl_en ? rd_pv[AW-1:0] : pa_g[AW-1:0]);
    nx_wd = clearing ? '0 : (unl_en ? rd_nx : head);

    pv_we = clearing || (unl_en && rd_nx < NIL) || (pa_en && pa_g < NIL) ||
            (pb_en && pb_g < NIL && head < NIL);
    if (clearing) begin
      pv_wa = clr; pv_wd = '0;
    end else if (unl_en) begin
      pv_wa = rd_nx[AW-1:0]; pv_wd = rd_pv;
    end else if (pa_en) begin
      pv_wa = pa_g[AW-1:0]; pv_wd = NIL;
    end else begin
      pv_wa = head[AW-1:0]; pv_wd = pb_g;
    end
  end

  always_ff @(posedge clk) begin
    if (bs_we) bs_mem[bs_wa] <= bs_wd;
    if (rd_en) rd_bs <= bs_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (iu_we) iu_mem[iu_wa] <= iu_wd;
    if (rd_en) rd_iu <= iu_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (fs_we) fs_mem[fs_wa] <= fs_wd;
    if (rd_en) rd_fs <= fs_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    if (rd_en) rd_nx <= nx_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    if (rd_en) rd_pv <= pv_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= NIL;
      started <= 1'b0;
      clr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == CMD_CLEAR) clr <= clr + AW'(1);
      if (cmd.op == CMD_INIT) begin
        started <= 1'b1;
        head <= '0;
      end else if (unl_en && rd_pv >= NIL) begin
        head <= (rd_nx < NIL) ? rd_nx : NIL;
      end else if (pb_en && pb_g < NIL) begin
        head <= pb_g;
      end
      if (cmd.op == CMD_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.st_we) st <= cmd.st;
    case (cmd.op)
      CMD_LATCH: begin
        act <= in_action;
        n <= in_bytes;
        off <= in_offset;
        want <= want_calc;
        st <= ST_OK;
        res <= '0;
        mv <= 1'b0;
        cp <= '0;
        grow <= 1'b0;
      end
      CMD_WALK_START: begin b <= head; visits <= '0; end
      CMD_WALK_NEXT: begin b <= rd_nx; visits <= visits + VW'(1); end
      CMD_TAKE: begin
        bsz <= rd_bs;
        res <= 16'({b + VW'(1), 4'b0000});
      end
      CMD_GROW: begin
        b <= g;
        bsz <= sz_plus_rd[VW-1:0];
        grow <= 1'b1;
        res <= off;
      end
      CMD_RELOC: begin
        mv <= 1'b1;
        cp <= (32'(cap) < n) ? 16'(cap) : n[15:0];
      end
      CMD_READ_G: g <= VW'(gcalc);
      CMD_READ_FOOT: sz <= rd_bs;
      CMD_INPLACE: res <= off;
      CMD_MERGE_NX: sz <= sz_plus_rd[VW-1:0];
      CMD_READ_PB: pb <= g - rd_fs;
      CMD_MERGE_PV: begin g <= pb; sz <= sz_plus_rd[VW-1:0]; end
      CMD_OUT: begin
        out_status <= st;
        out_offset <= res;
        out_moved <= mv;
        out_copy <= cp;
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_head_range: assert property (@(posedge clk) disable iff (rst) head <= NIL)
    else $error("free-list head out of range");
  a_started_sticky: assert property (@(posedge clk) disable iff (rst) started |=> started)
    else $error("arena start flag dropped");
  a_out_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.op == CMD_OUT))
    else $error("result appeared without a load");
  a_split_fits: assert property (@(posedge clk) disable iff (rst)
    cmd.op == CMD_SPLIT1 |-> WW'(bsz) >= want)
    else $error("split of a block that is too small");
`endif

endmodule

### sv/ffha_ctrl.sv
module ffha_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ffha_pkg::stat_t stat,
  output ffha_pkg::cmd_t  cmd
);
  import ffha_pkg::*;

  state_t state, state_next;
  logic   is_resize;

  assign is_resize = (stat.act == ACT_RESIZE);
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (stat.clr_last) state_next = S_IDLE;
      S_IDLE: if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        case (stat.act)
          ACT_ALLOC: state_next = S_GRAB;
          ACT_FREE: state_next = stat.off_zero ? S_DONE : S_CK0;
          ACT_RESIZE: state_next = stat.off_zero ? S_GRAB : S_CK0;
          default: state_next = S_DONE;
        endcase
      end
      S_GRAB: state_next = stat.n_zero ? S_DONE : S_GRAB_SZ;
      S_GRAB_SZ: state_next = stat.n_big ? S_DONE : S_WALK;
      S_WALK: state_next = stat.walk_end ? S_DONE : S_WALK_EV;
      S_WALK_EV: state_next = stat.walk_fit ? S_SPLIT_CHK : S_WALK;
      S_SPLIT_CHK: state_next = stat.split_ok ? S_SPLIT2 : S_AFTER;
      S_SPLIT2: state_next = S_SPLIT3;
      S_SPLIT3: state_next = S_AFTER;
      S_AFTER: begin
        if (!stat.grow && is_resize && !stat.off_zero) state_next = S_REL0;
        else state_next = S_DONE;
      end
      S_CK0: state_next = stat.pre_ok ? S_CK1 : S_DONE;
      S_CK1: state_next = stat.ck1_ok ? S_CK2 : S_DONE;
      S_CK2: begin
        if (!stat.ck2_ok) state_next = S_DONE;
        else if (is_resize && !stat.n_zero) state_next = S_RSZ0;
        else state_next = S_REL0;
      end
      S_RSZ0: begin
        if (stat.inplace) state_next = S_DONE;
        else if (stat.nx_in) state_next = S_RSZ1;
        else state_next = S_GRAB;
      end
      S_RSZ1: state_next = stat.grow_fit ? S_SPLIT_CHK : S_GRAB;
      S_REL0: state_next = S_REL1;
      S_REL1: state_next = stat.nx_in ? S_REL2 : S_REL3;
      S_REL2: state_next = S_REL3;
      S_REL3: state_next = stat.g_nz ? S_REL4 : S_REL6;
      S_REL4: state_next = stat.prev_ok ? S_REL5 : S_REL6;
      S_REL5: state_next = S_REL6;
      S_REL6: state_next = S_REL7;
      S_REL7: state_next = S_DONE;
      S_DONE: if (!stat.out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = CMD_NOP;
    cmd.st_we = 1'b0;
    cmd.st = ST_OK;
    unique case (state)
      S_CLEAR: cmd.op = CMD_CLEAR;
      S_IDLE: if (in_valid) cmd.op = CMD_LATCH;
      S_DISPATCH: ;
      S_GRAB: begin
        if (stat.n_zero) begin
          cmd.st_we = 1'b1; cmd.st = ST_NULL;
        end else if (!stat.started) begin
          cmd.op = CMD_INIT;
        end
      end
      S_GRAB_SZ: begin
        if (stat.n_big) begin
          cmd.st_we = 1'b1; cmd.st = ST_OOM;
        end else begin
          cmd.op = CMD_WALK_START;
        end
      end
      S_WALK: begin
        if (stat.walk_end) begin
          cmd.st_we = 1'b1; cmd.st = ST_OOM;
        end else begin
          cmd.op = CMD_READ_B;
        end
      end
      S_WALK_EV: cmd.op = stat.walk_fit ? CMD_TAKE : CMD_WALK_NEXT;
      S_SPLIT_CHK: cmd.op = stat.split_ok ? CMD_SPLIT1 : CMD_NOSPLIT;
      S_SPLIT2: cmd.op = CMD_SPLIT2;
      S_SPLIT3: cmd.op = CMD_PUSHB_C;
      S_AFTER: if (!stat.grow && is_resize && !stat.off_zero) cmd.op = CMD_RELOC;
      S_CK0: begin
        if (stat.pre_ok) cmd.op = CMD_READ_G;
        else begin cmd.st_we = 1'b1; cmd.st = ST_BADPTR; end
      end
      S_CK1: begin
        if (stat.ck1_ok) cmd.op = CMD_READ_FOOT;
        else begin cmd.st_we = 1'b1; cmd.st = ST_BADPTR; end
      end
      S_CK2: if (!stat.ck2_ok) begin cmd.st_we = 1'b1; cmd.st = ST_BADPTR; end
      S_RSZ0: begin
        if (stat.inplace) cmd.op = CMD_INPLACE;
        else if (stat.nx_in) cmd.op = CMD_READ_NX;
      end
      S_RSZ1: if (stat.grow_fit) cmd.op = CMD_GROW;
      S_REL0: cmd.op = CMD_FREE_MARK;
      S_REL1: if (stat.nx_in) cmd.op = CMD_READ_NX;
      S_REL2: if (stat.rd_free) cmd.op = CMD_MERGE_NX;
      S_REL3: if (stat.g_nz) cmd.op = CMD_READ_PREVF;
      S_REL4: if (stat.prev_ok) cmd.op = CMD_READ_PB;
      S_REL5: if (stat.rd_free) cmd.op = CMD_MERGE_PV;
      S_REL6: cmd.op = CMD_REL_TAG;
      S_REL7: begin
        cmd.op = CMD_PUSHB_G;
        if (is_resize && stat.n_zero) begin cmd.st_we = 1'b1; cmd.st = ST_NULL; end
      end
      S_DONE: if (!stat.out_busy) cmd.op = CMD_OUT;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_latch_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.op == CMD_LATCH |=> state == S_DISPATCH)
    else $error("request latched outside dispatch flow");
  a_out_done: assert property (@(posedge clk) disable iff (rst)
    cmd.op == CMD_OUT |=> state == S_IDLE)
    else $error("result load did not return to idle");
  a_clear_first: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !in_ready)
    else $error("request taken during the clearing pass");
`endif

endmodule

### sv/first_fit_heap_allocator.sv
// First-fit heap allocator over a 4096-granule arena of 16-byte granules.
// Requests enter on the s_ channel: s_tuser carries the action (allocate,
// release, resize), s_tdata the byte count and the payload offset. Each
// request yields exactly one result on the m_ channel: m_tuser carries the
// status, m_tdata the granted offset, the moved flag and the copy length.
// Requests are handled one at a time by a sequencer over the tag memories,
// one memory access per step. An allocate steps through the walk once more
// for every free-list entry that it skips, and splitting a block adds steps
// over taking it whole. A release checks the neighbors on both sides for
// merging. A relocating resize adds the walk and a release. The next request
// can be taken once the result is loaded.
// After reset the tag memories are cleared one granule per cycle, so s_tready
// stays low until every granule is cleared. A result waits in the output
// register while m_tready is low; the sequencer holds its next result until
// the waiting one is taken, but a request already finished frees s_tready
// as soon as the result register is loaded.
module first_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // request_bytes[31:0], payload_offset[47:32]
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // result_offset[15:0], moved[16], copy_bytes[32:17], zeros
  output logic [1:0]  m_tuser    // status[1:0]
);
  import ffha_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  status_t     out_status;
  logic [15:0] out_offset, out_copy;
  logic        out_moved;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffha_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_action  (s_tuser),
    .in_bytes   (s_tdata[31:0]),
    .in_offset  (s_tdata[47:32]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_offset (out_offset),
    .out_moved  (out_moved),
    .out_copy   (out_copy)
  );

  assign m_tdata = {7'd0, out_copy, out_moved, out_offset};
  assign m_tuser = out_status;

endmodule
